// File: rtl/vss_pkg.sv
// ---------------------------------------------------------------------------
// vss_pkg: shared types and constants of the vector similarity scorer
// Widths, metric codes, controller/datapath command and status structs,
// and small arithmetic helpers.
// ---------------------------------------------------------------------------
package vss_pkg;

  localparam int ElemW  = 16;
  localparam int AccW   = 48;
  localparam int ProdW  = 2 * ElemW + 1;   // product, sign-extended by one bit
  localparam int RootW  = AccW / 2;
  localparam int RemW   = RootW + 2;
  localparam int FracW  = 30;
  localparam int DvdW   = AccW + FracW;
  localparam int CntW   = 7;
  localparam logic [CntW-1:0] SqrtSteps = CntW'(RootW);
  localparam logic [CntW-1:0] DivSteps  = CntW'(DvdW);

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  // metric codes; code 3 behaves as L2
  localparam logic [1:0] MODE_DOT = 2'd0;
  localparam logic [1:0] MODE_COS = 2'd1;
  localparam logic [1:0] MODE_L2  = 2'd2;

  typedef struct packed {
    logic acc_en;     // accumulate the current beat
    logic prep;       // load square-root units from the sums
    logic sqrt_step;  // one digit of both square roots
    logic mul;        // den = root_q * root_c
    logic div_load;   // load the divider
    logic div_step;   // one quotient bit
    logic finish;     // load result register, clear sums
  } vss_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       out_free;
  } vss_status_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } vss_root_t;

  // saturating add of a product to an accumulator
  function automatic logic signed [AccW-1:0] sat_acc(
      input logic signed [AccW-1:0] a, input logic signed [ProdW-1:0] b);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} + (AccW+1)'(b);
    if (s[AccW] != s[AccW-1]) begin
      return s[AccW] ? AccMin : AccMax;
    end
    return s[AccW-1:0];
  endfunction

  // one digit of the restoring square root: two input bits in
  function automatic vss_root_t sqrt_digit(
      input vss_root_t cur, input logic [1:0] bits2);
    vss_root_t        nxt;
    logic [RemW-1:0]  r;
    logic [RemW-1:0]  trial;
    r     = {cur.rem[RemW-3:0], bits2};
    trial = {cur.root, 2'b01};
    if (r >= trial) begin
      nxt.rem  = r - trial;
      nxt.root = {cur.root[RootW-2:0], 1'b1};
    end else begin
      nxt.rem  = r;
      nxt.root = {cur.root[RootW-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

// File: rtl/vss_if.sv
// ---------------------------------------------------------------------------
// vss_if: valid/ready channels of the vector similarity scorer
// Element-pair input, score output and metric configuration write.
// ---------------------------------------------------------------------------
interface vss_elem_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] query_elem;
  logic signed [15:0] cand_elem;
  logic               last_elem;
  modport source (output valid, query_elem, cand_elem, last_elem, input ready);
  modport sink   (input valid, query_elem, cand_elem, last_elem, output ready);
endinterface

interface vss_result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] score;
  logic               score_valid;
  modport source (output valid, score, score_valid, input ready);
  modport sink   (input valid, score, score_valid, output ready);
endinterface

interface vss_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/vss_ctrl.sv
// ---------------------------------------------------------------------------
// vss_ctrl: sequencer of the vector similarity scorer
// Streams beats into the accumulators, then runs the scoring sequence (cosine only) and writes the score.
// ---------------------------------------------------------------------------
module vss_ctrl
  import vss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_ready,
  input  vss_status_t status,
  output vss_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_ACC, S_PREP, S_SQRT, S_MUL, S_DLOAD, S_DIV, S_FIN
  } state_t;

  state_t          state, state_next;
  logic [CntW-1:0] cnt, cnt_next;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_ACC: begin
        in_ready   = 1'b1;
        cmd.acc_en = in_valid;
        if (in_valid && in_last) begin
          state_next = (status.mode == MODE_COS) ? S_PREP : S_FIN;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == SqrtSteps - 1'b1) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DivSteps - 1'b1) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// File: rtl/vss_dp.sv
// ---------------------------------------------------------------------------
// vss_dp: datapath of the vector similarity scorer
// Saturating accumulators, two square-root units, multiplier, bit-serial
// divider and the result register.
// ---------------------------------------------------------------------------
module vss_dp
  import vss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [ElemW-1:0] query_elem,
  input  logic signed [ElemW-1:0] cand_elem,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_data,
  input  vss_cmd_t                cmd,
  output vss_status_t             status,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [AccW-1:0]  score,
  output logic                    score_valid
);

  logic [1:0]             metric_mode;
  logic signed [AccW-1:0] dot_sum, diff_sq_sum, query_norm_sum, cand_norm_sum;
  logic [AccW-1:0]        qx, cx;
  vss_root_t              qsq, csq;
  logic [AccW-1:0]        den;
  logic [DvdW-1:0]        dvd;
  logic [AccW-1:0]        rem, quo;
  logic                   ovf;

  // element products
  logic signed [ElemW:0]   diff;
  logic [ElemW-1:0]        adiff;
  logic signed [ProdW-1:0] p_dot, p_diff, p_qq, p_cc;
  assign diff   = {query_elem[ElemW-1], query_elem} - {cand_elem[ElemW-1], cand_elem};
  assign adiff  = diff[ElemW] ? ElemW'(-diff) : diff[ElemW-1:0];
  assign p_dot  = ProdW'(query_elem) * ProdW'(cand_elem);
  assign p_qq   = ProdW'(query_elem) * ProdW'(query_elem);
  assign p_cc   = ProdW'(cand_elem) * ProdW'(cand_elem);
  assign p_diff = {1'b0, (2*ElemW)'(adiff) * (2*ElemW)'(adiff)};

  // divider step
  logic [AccW:0] dtrial;
  assign dtrial = {rem, dvd[DvdW-1]};

  // dot magnitude (|dot| <= 2^47 fits unsigned)
  logic [AccW-1:0] dot_mag;
  assign dot_mag = dot_sum[AccW-1] ? AccW'(-dot_sum) : dot_sum;

  // final score selection
  logic signed [AccW-1:0] score_next;
  logic                   valid_next;
  logic [AccW-1:0]        cos_mag;
  always_comb begin
    cos_mag    = (ovf || quo[AccW-1]) ? AccMax : quo;
    valid_next = 1'b1;
    case (metric_mode)
      MODE_DOT: score_next = (dot_sum == AccMin) ? -AccMax : dot_sum;
      MODE_COS: begin
        if (den == '0) begin
          score_next = '0;
          valid_next = 1'b0;
        end else begin
          score_next = dot_sum[AccW-1] ? -$signed(cos_mag) : $signed(cos_mag);
        end
      end
      default:  score_next = -diff_sq_sum;
    endcase
  end

  assign status.mode     = metric_mode;
  assign status.out_free = !out_valid || out_ready;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= MODE_DOT;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        metric_mode <= cfg_data;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      dot_sum        <= '0;
      diff_sq_sum    <= '0;
      query_norm_sum <= '0;
      cand_norm_sum  <= '0;
    end else if (cmd.acc_en) begin
      dot_sum        <= sat_acc(dot_sum, p_dot);
      diff_sq_sum    <= sat_acc(diff_sq_sum, p_diff);
      query_norm_sum <= sat_acc(query_norm_sum, p_qq);
      cand_norm_sum  <= sat_acc(cand_norm_sum, p_cc);
    end
  end

  // scoring pipeline: square roots, product, division
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      qx  <= query_norm_sum;
      cx  <= cand_norm_sum;
      qsq <= '0;
      csq <= '0;
    end else if (cmd.sqrt_step) begin
      qx  <= {qx[AccW-3:0], 2'b00};
      cx  <= {cx[AccW-3:0], 2'b00};
      qsq <= sqrt_digit(qsq, qx[AccW-1:AccW-2]);
      csq <= sqrt_digit(csq, cx[AccW-1:AccW-2]);
    end
    if (cmd.mul) begin
      den <= qsq.root * csq.root;
    end
    if (cmd.div_load) begin
      dvd <= {dot_mag, {FracW{1'b0}}};
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[DvdW-2:0], 1'b0};
      ovf <= ovf | quo[AccW-1];
      if (dtrial >= {1'b0, den}) begin
        rem <= AccW'(dtrial - {1'b0, den});
        quo <= {quo[AccW-2:0], 1'b1};
      end else begin
        rem <= dtrial[AccW-1:0];
        quo <= {quo[AccW-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      score       <= score_next;
      score_valid <= valid_next;
    end
  end

endmodule

// File: rtl/vector_similarity_score_top.sv
// ---------------------------------------------------------------------------
// vector_similarity_score_top: streaming dot / cosine / L2 scorer
// Top level joining the sequencer and the datapath.
// ---------------------------------------------------------------------------
// One element pair is taken per cycle while a vector streams in; four
// saturating Q18.30 sums are kept. Inner-product and L2 scores go from the
// sums into the output register in the finish state, which follows the beat
// marked last. Cosine first runs a load of the two digit-serial square-root
// units, their digit steps, a multiply, a divider load and the steps of the
// bit-serial divider; no beat is taken meanwhile, nor in the cycle in which
// the score is written (longer while the output register still holds an
// unread score). A finished score sits in an output register, and the next
// vector streams in while it waits. Configuration writes are always taken.
module vector_similarity_score_top
  import vss_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  vss_elem_if.sink     elem,
  vss_result_if.source result,
  vss_cfg_if.sink      cfg
);

  vss_cmd_t    cmd;
  vss_status_t status;

  assign cfg.ready = 1'b1;

  vss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (elem.valid),
    .in_last  (elem.last_elem),
    .in_ready (elem.ready),
    .status   (status),
    .cmd      (cmd)
  );

  vss_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .query_elem  (elem.query_elem),
    .cand_elem   (elem.cand_elem),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .score       (result.score),
    .score_valid (result.score_valid)
  );

endmodule
